>>> rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch bump allocator package
// Field widths, status codes and fixed limits shared by the allocator RTL.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int SIZE_W      = 12;
  localparam int ADDR_W      = 15;
  localparam int CNT_W       = 12;
  localparam int STAT_W      = 3;
  localparam int BATCH_STORE = 2000;
  localparam int DIV_K       = 20;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_ALLOC    = 3'd0;
  localparam status_t ST_OOM      = 3'd1;
  localparam status_t ST_RELEASED = 3'd2;
  localparam status_t ST_REVIVED  = 3'd3;
  localparam status_t ST_OVER     = 3'd4;

endpackage

>>> rtl/core/batch_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch bump allocator
// Pool of equal batches with bump allocation, per-batch release counting,
// dead marking on overflow and a free stack of revived batches.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears on status and block_address for one cycle with done high,
// and the receiver cannot stall it. An allocate carves from the current
// batch; on overflow a batch is popped from the free stack and the carve is
// tried once more. For a deallocate the batch index comes from a registered
// reciprocal multiply and a correction step, then the counter memory is read
// and updated, unless the address lies beyond the pool. One add-compare unit
// checks both allocate fits and release bounds, and the counter and stack
// memories each give one registered read per cycle. Per-entry valid bits
// stand in for reset values, so no clearing pass follows reset.
module batch_bump_allocator import bba_pkg::*; #(
  parameter int BATCH_BYTES = 2048,
  parameter int NUM_BATCHES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              action,
  input  logic [SIZE_W-1:0] size,
  input  logic [ADDR_W-1:0] address,
  output logic              busy,
  output logic              done,
  output status_t           status,
  output logic [ADDR_W-1:0] block_address
);

  localparam int BW       = $clog2(NUM_BATCHES);
  localparam int FC_W     = $clog2(NUM_BATCHES + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int CAP      = (BATCH_STORE < BATCH_BYTES) ? BATCH_STORE : BATCH_BYTES;
  localparam int RECIP    = (1 << DIV_K) / BATCH_BYTES;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = ADDR_W + RECIP_W;
  localparam int Q_W      = ADDR_W + 1;
  localparam int BB_W     = $clog2(BATCH_BYTES + 1);
  localparam int QB_W     = Q_W + BB_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CARVE = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_DIV1  = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_REL   = 3'd5;

  logic [2:0]             state, state_next;
  logic [FC_W-1:0]        fc, fc_next, fc_m1;
  logic [BW-1:0]          cur, cur_next;
  logic [BW-1:0]          bat, bat_next;
  logic                   second, second_next;
  logic [NUM_BATCHES-1:0] dead;
  logic [NUM_BATCHES-1:0] cnt_vld;
  logic [NUM_BATCHES-1:0] stk_vld;

  logic [2*CNT_W-1:0]     cnt_mem [NUM_BATCHES];
  logic [BW-1:0]          stk_mem [NUM_BATCHES];
  logic [2*CNT_W-1:0]     cnt_q;
  logic                   cnt_vq;
  logic [BW-1:0]          stk_q;
  logic                   stk_vq;

  logic                   action_q;
  logic [SIZE_W-1:0]      size_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [PROD_W-1:0]      prod;
  logic [Q_W-1:0]         q0, q0_q, q_fix;
  logic [QB_W-1:0]        qb, rem;

  logic [BW-1:0]          rd_idx, wr_idx, stk_ridx, popped, pop_rst;
  logic [CNT_W-1:0]       used_rd, rel_rd, add_a;
  logic [SUM_W-1:0]       sum, limit;
  logic                   fail;
  logic                   cnt_we, cnt_clr, dead_set, dead_clr, stk_we;
  logic [2*CNT_W-1:0]     cnt_wdata;
  logic                   done_next;
  status_t                status_next;
  logic [ADDR_W-1:0]      blk_next;
  logic [31:0]            blk_full;

  assign busy     = (state != S_IDLE);
  assign fc_m1    = fc - FC_W'(1);
  assign stk_ridx = fc_m1[BW-1:0];
  assign used_rd  = cnt_vq ? cnt_q[CNT_W-1:0] : '0;
  assign rel_rd   = cnt_vq ? cnt_q[2*CNT_W-1:CNT_W] : '0;
  assign pop_rst  = (fc < FC_W'(NUM_BATCHES - 2)) ? fc[BW-1:0] : '0;
  assign popped   = stk_vq ? stk_q : pop_rst;

  assign add_a    = (state == S_REL) ? rel_rd : used_rd;
  assign limit    = (state == S_REL) ? SUM_W'(used_rd) : SUM_W'(CAP);
  assign sum      = SUM_W'(add_a) + SUM_W'(size_q);
  assign fail     = (sum > limit);

  assign q0       = Q_W'(prod >> DIV_K);
  assign rem      = QB_W'(addr_q) - qb;
  assign q_fix    = (rem >= QB_W'(BATCH_BYTES)) ? (q0_q + Q_W'(1)) : q0_q;
  assign blk_full = 32'(cur) * 32'(BATCH_BYTES) + 32'(used_rd);
  assign wr_idx   = (state == S_REL) ? bat : cur;

  always_comb begin
    state_next  = state;
    fc_next     = fc;
    cur_next    = cur;
    bat_next    = bat;
    second_next = second;
    rd_idx      = cur;
    cnt_we      = 1'b0;
    cnt_clr     = 1'b0;
    cnt_wdata   = {rel_rd, used_rd};
    dead_set    = 1'b0;
    dead_clr    = 1'b0;
    stk_we      = 1'b0;
    done_next   = 1'b0;
    status_next = status;
    blk_next    = block_address;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          second_next = 1'b0;
          state_next  = action ? S_DIV1 : S_CARVE;
        end
      end
      S_CARVE: begin
        if (!fail) begin
          cnt_we      = 1'b1;
          cnt_wdata   = {rel_rd, sum[CNT_W-1:0]};
          done_next   = 1'b1;
          status_next = ST_ALLOC;
          blk_next    = blk_full[ADDR_W-1:0];
          state_next  = S_IDLE;
        end else begin
          dead_set = 1'b1;
          if (second || fc == '0) begin
            done_next   = 1'b1;
            status_next = ST_OOM;
            blk_next    = '0;
            state_next  = S_IDLE;
          end else begin
            fc_next    = fc_m1;
            state_next = S_POP;
          end
        end
      end
      S_POP: begin
        cur_next    = popped;
        rd_idx      = popped;
        second_next = 1'b1;
        state_next  = S_CARVE;
      end
      S_DIV1: begin
        state_next = S_DIV2;
      end
      S_DIV2: begin
        if (q_fix >= Q_W'(NUM_BATCHES)) begin
          done_next   = 1'b1;
          status_next = ST_OVER;
          blk_next    = '0;
          state_next  = S_IDLE;
        end else begin
          bat_next   = q_fix[BW-1:0];
          rd_idx     = q_fix[BW-1:0];
          state_next = S_REL;
        end
      end
      S_REL: begin
        done_next  = 1'b1;
        blk_next   = '0;
        state_next = S_IDLE;
        if (fail) begin
          status_next = ST_OVER;
        end else if (dead[bat] && sum == SUM_W'(used_rd)) begin
          cnt_clr     = 1'b1;
          dead_clr    = 1'b1;
          status_next = ST_REVIVED;
          if (fc < FC_W'(NUM_BATCHES)) begin
            stk_we  = 1'b1;
            fc_next = fc + FC_W'(1);
          end
        end else begin
          cnt_we      = 1'b1;
          cnt_wdata   = {sum[CNT_W-1:0], used_rd};
          status_next = ST_RELEASED;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fc      <= FC_W'(NUM_BATCHES - 2);
      cur     <= BW'(NUM_BATCHES - 2);
      second  <= 1'b0;
      dead    <= '0;
      cnt_vld <= '0;
      stk_vld <= '0;
      done    <= 1'b0;
    end else begin
      state  <= state_next;
      fc     <= fc_next;
      cur    <= cur_next;
      second <= second_next;
      done   <= done_next;
      if (dead_set) dead[wr_idx] <= 1'b1;
      if (dead_clr) dead[wr_idx] <= 1'b0;
      if (cnt_we) cnt_vld[wr_idx] <= 1'b1;
      if (cnt_clr) cnt_vld[wr_idx] <= 1'b0;
      if (stk_we) stk_vld[fc[BW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bat           <= bat_next;
    status        <= status_next;
    block_address <= blk_next;
    q0_q          <= q0;
    qb            <= QB_W'(q0) * QB_W'(BATCH_BYTES);
    if (start && !busy) begin
      action_q <= action;
      size_q   <= size;
      addr_q   <= address;
      prod     <= PROD_W'(address) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    cnt_q  <= cnt_mem[rd_idx];
    cnt_vq <= cnt_vld[rd_idx];
    stk_q  <= stk_mem[stk_ridx];
    stk_vq <= stk_vld[stk_ridx];
    if (cnt_we) cnt_mem[wr_idx] <= cnt_wdata;
    if (stk_we) stk_mem[fc[BW-1:0]] <= bat;
  end

  a_action_path: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == (action_q ? S_DIV1 : S_CARVE)))
    else $error("accepted transaction took the wrong path");

  a_blk_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_ALLOC) |-> (block_address == '0))
    else $error("block address set on a non-allocate result");

  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= FC_W'(NUM_BATCHES))
    else $error("free stack count out of range");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in progress");

endmodule

>>> dv/batch_bump_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch bump allocator testbench
// Drives allocate and deallocate transactions through the start/busy
// handshake and predicts every status and block address with an in-order
// allocator model. Directed corner cases come first, then random traffic in
// fill, drain and mixed phases with random idle gaps. Each done strobe is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module batch_bump_allocator_tb import bba_pkg::*;;

  localparam int BATCH_BYTES = 2048;
  localparam int NUM_BATCHES = 16;
  localparam int CAPACITY    = (BATCH_STORE < BATCH_BYTES) ? BATCH_STORE : BATCH_BYTES;
  localparam int MAX_SIZE    = 2048;
  localparam int MAX_ADDR    = (1 << ADDR_W) - 1;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] block;
  } outcome_t;

  typedef struct {
    int unsigned addr;
    int unsigned sz;
  } live_block_t;

  class allocator_scoreboard;
    int unsigned carved   [NUM_BATCHES];
    int unsigned released [NUM_BATCHES];
    bit          dead     [NUM_BATCHES];
    int unsigned free_ids [NUM_BATCHES];
    int unsigned free_top;
    int unsigned cur_batch;
    outcome_t    expected_outcomes[$];
    int          errors;

    function new();
      int i;
      for (i = 0; i < NUM_BATCHES; i++) begin
        carved[i]   = 0;
        released[i] = 0;
        dead[i]     = 1'b0;
        free_ids[i] = (i < NUM_BATCHES - 2) ? i : 0;
      end
      free_top  = NUM_BATCHES - 2;
      cur_batch = NUM_BATCHES - 2;
      errors    = 0;
    endfunction

    function bit carve(int unsigned b, int unsigned sz, output int unsigned off);
      off = carved[b];
      if (carved[b] + sz > CAPACITY) begin
        dead[b] = 1'b1;
        return 1'b0;
      end
      carved[b] += sz;
      return 1'b1;
    endfunction

    function outcome_t note_transaction(logic act, int unsigned sz, int unsigned addr);
      outcome_t    o;
      int unsigned b;
      int unsigned off;
      o.status = ST_OOM;
      o.block  = '0;
      if (act == ACT_ALLOC) begin
        b = cur_batch;
        if (carve(b, sz, off)) begin
          o.status = ST_ALLOC;
          o.block  = ADDR_W'(b * BATCH_BYTES + off);
        end else if (free_top > 0) begin
          free_top--;
          b         = free_ids[free_top];
          cur_batch = b;
          if (carve(b, sz, off)) begin
            o.status = ST_ALLOC;
            o.block  = ADDR_W'(b * BATCH_BYTES + off);
          end
        end
      end else begin
        b = addr / BATCH_BYTES;
        if (b >= NUM_BATCHES) begin
          o.status = ST_OVER;
        end else if (released[b] + sz > carved[b]) begin
          o.status = ST_OVER;
        end else begin
          released[b] += sz;
          if (dead[b] && released[b] == carved[b]) begin
            carved[b]   = 0;
            released[b] = 0;
            dead[b]     = 1'b0;
            // drop the push when the stack is already full
            if (free_top < NUM_BATCHES) begin
              free_ids[free_top] = b;
              free_top++;
            end
            o.status = ST_REVIVED;
          end else begin
            o.status = ST_RELEASED;
          end
        end
      end
      expected_outcomes = {expected_outcomes, o};
      return o;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(status_t st, logic [ADDR_W-1:0] blk);
      outcome_t o;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d block %0d", st, blk));
        return;
      end
      o = expected_outcomes.pop_front();
      if (st !== o.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, o.status));
      if (blk !== o.block)
        report_mismatch($sformatf("block_address %0d, expected %0d", blk, o.block));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              action;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;
  logic              busy;
  logic              done;
  status_t           status;
  logic [ADDR_W-1:0] block_address;

  allocator_scoreboard sb;
  live_block_t         live_blocks[$];
  bit                  no_idle;
  int                  cycles = 0;

  batch_bump_allocator #(
    .BATCH_BYTES(BATCH_BYTES),
    .NUM_BATCHES(NUM_BATCHES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .size         (size),
    .address      (address),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .block_address(block_address)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(status, block_address);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_size(bit big);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (big && r < 70) return $urandom_range(200, 1800);
    if (r < 5) return 0;
    if (r < 60) return $urandom_range(1, 255);
    if (r < 85) return $urandom_range(256, 1000);
    if (r < 96) return $urandom_range(1001, CAPACITY);
    return $urandom_range(CAPACITY + 1, MAX_SIZE);
  endfunction

  task automatic issue(input logic act, input int unsigned sz, input int unsigned addr);
    outcome_t    o;
    live_block_t lb;
    int unsigned gap;
    int          k;
    action  <= act;
    size    <= sz[SIZE_W-1:0];
    address <= addr[ADDR_W-1:0];
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    o = sb.note_transaction(act, sz, addr);
    if (act == ACT_ALLOC && o.status == ST_ALLOC && sz > 0) begin
      lb.addr     = int'(o.block);
      lb.sz       = sz;
      live_blocks = {live_blocks, lb};
    end
    // forget blocks of a batch that was just cleared
    if (o.status == ST_REVIVED) begin
      for (k = live_blocks.size() - 1; k >= 0; k--)
        if (live_blocks[k].addr / BATCH_BYTES == addr / BATCH_BYTES)
          live_blocks.delete(k);
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_outcomes();
    start <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Release dead batches that hold nothing, current batch first.
  task automatic revive_empty_dead();
    int unsigned base;
    int unsigned b;
    int          k;
    base = sb.cur_batch;
    for (k = 0; k < NUM_BATCHES; k++) begin
      b = (base + k) % NUM_BATCHES;
      if (sb.dead[b] && sb.carved[b] == sb.released[b])
        issue(ACT_FREE, 0, b * BATCH_BYTES + $urandom_range(0, BATCH_BYTES - 1));
    end
  endtask

  initial begin
    int          seg;
    int          n;
    int unsigned r;
    int unsigned p;
    int unsigned part;
    int unsigned sz;
    int unsigned alloc_pct;
    int          k;
    live_block_t blk;

    sb      = new();
    no_idle = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    action  <= ACT_ALLOC;
    size    <= '0;
    address <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_ALLOC, CAPACITY, 0);
    issue(ACT_ALLOC, 0, MAX_ADDR);
    issue(ACT_ALLOC, 1, 0);
    issue(ACT_FREE, CAPACITY, (NUM_BATCHES - 2) * BATCH_BYTES);
    issue(ACT_FREE, 1, (NUM_BATCHES - 3) * BATCH_BYTES + 5);
    issue(ACT_FREE, 1, (NUM_BATCHES - 3) * BATCH_BYTES);
    issue(ACT_FREE, MAX_SIZE, MAX_ADDR);
    issue(ACT_FREE, 0, 0);
    issue(ACT_ALLOC, MAX_SIZE, 0);
    // grow the free stack until a revived batch no longer fits on it
    repeat (2) begin
      revive_empty_dead();
      issue(ACT_ALLOC, MAX_SIZE, 0);
    end
    revive_empty_dead();

    // random phases: fill, drain, mixed
    for (seg = 0; seg < 9; seg++) begin
      wait_for_outcomes();
      no_idle   = ($urandom_range(0, 3) == 0);
      alloc_pct = (seg % 3 == 0) ? 90 : (seg % 3 == 1) ? 25 : 55;
      for (n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          if ($urandom_range(0, 1))
            issue(ACT_FREE, $urandom_range(0, MAX_SIZE), $urandom_range(0, MAX_ADDR));
          else
            issue(ACT_ALLOC, $urandom_range(0, MAX_SIZE), $urandom_range(0, MAX_ADDR));
        end else if (r < 9) begin
          revive_empty_dead();
        end else if (r < alloc_pct) begin
          issue(ACT_ALLOC, pick_size(seg % 3 == 0), $urandom_range(0, MAX_ADDR));
        end else if (live_blocks.size() > 0) begin
          k   = $urandom_range(0, live_blocks.size() - 1);
          blk = live_blocks[k];
          live_blocks.delete(k);
          p = $urandom_range(0, 9);
          if (p < 7) begin
            issue(ACT_FREE, blk.sz, blk.addr);
          end else if (p < 9) begin
            part = $urandom_range(1, blk.sz);
            if (part < blk.sz) begin
              blk.sz      = blk.sz - part;
              live_blocks = {live_blocks, blk};
            end
            issue(ACT_FREE, part, blk.addr);
          end else begin
            sz = blk.sz + $urandom_range(1, 48);
            if (sz > MAX_SIZE) sz = MAX_SIZE;
            issue(ACT_FREE, sz, blk.addr);
          end
        end else begin
          issue(ACT_FREE, 0, $urandom_range(0, MAX_ADDR));
        end
      end
    end

    wait_for_outcomes();
    repeat (20) @(posedge clk);
    if (sb.expected_outcomes.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_outcomes.size()));
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> batch_bump_allocator.f
rtl/core/bba_pkg.sv
rtl/core/batch_bump_allocator.sv
dv/batch_bump_allocator_tb.sv
